// ----- design/msrc_pkg.sv -----
package msrc_pkg;

  localparam int unsigned HEAD_KEEP = 7;
  localparam int unsigned CountW    = 5;
  localparam logic [CountW-1:0] COUNT_MAX = 5'd31;
  localparam logic [CountW-1:0] MIN_FRAME_LEN = 5'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // divide by 10: x * ceil(2^19 / 10) >> 19, exact for any 16-bit x
  localparam logic [15:0] DIV10_MUL = 16'd52429;

  // configuration register indexes
  localparam logic [2:0] REG_MAX_FRAME_LEN  = 3'd0;
  localparam logic [2:0] REG_PRESSURE_ADDR  = 3'd1;
  localparam logic [2:0] REG_SOIL_ADDR      = 3'd2;
  localparam logic [2:0] REG_READ_FUNC      = 3'd3;
  localparam logic [2:0] REG_PRESSURE_COUNT = 3'd4;

  // config reset values
  localparam logic [4:0] MAX_FRAME_LEN_RST  = 5'd20;
  localparam logic [7:0] PRESSURE_ADDR_RST  = 8'h01;
  localparam logic [7:0] SOIL_ADDR_RST      = 8'h02;
  localparam logic [7:0] READ_FUNC_RST      = 8'h03;
  localparam logic [7:0] PRESSURE_COUNT_RST = 8'h02;

  // result kinds
  localparam logic [1:0] KIND_FAIL     = 2'd0;
  localparam logic [1:0] KIND_PRESSURE = 2'd1;
  localparam logic [1:0] KIND_SOIL     = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] pressure;
    logic [12:0] humidity;
    logic [12:0] temperature;
  } out_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = {16'h0000, x} * {16'h0000, DIV10_MUL};
    return p[31:19];
  endfunction

endpackage

// ----- design/modbus_sensor_reply_checker.sv -----
// Modbus RTU reply checker for a pressure sensor and a soil sensor.
//
// Input channel (in_valid_i / in_ready_o / in_i): one reply byte per
// transfer, with last_byte marking the final byte of a frame. CRC-16
// (preset 0xFFFF, reflected poly 0xA001) runs over every byte including
// the CRC itself, so a good frame leaves a zero residue.
// Output channel (out_valid_o / out_ready_i / out_o): exactly one result per
// frame, produced by the last byte; other bytes produce nothing.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i;
// unknown indexes are ignored. Write only while idle.
//
// Pipeline: input register, frame/CRC/decision stage, divide stage, output
// register. A result passes from the input register through the decision
// register into out_o. One byte per cycle is taken while the output is
// not stalled; the CRC update is an 8-step unrolled byte update in the
// decision stage. A stall at the output backs up through the three stages;
// bytes that are not last still drain into the frame state.
// Reset: config returns to defaults, frame state clears, no result pending.
module modbus_sensor_reply_checker
  import msrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_o
);

  // configuration
  logic [4:0] max_len_q;
  logic [7:0] press_addr_q, soil_addr_q, read_func_q, press_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= MAX_FRAME_LEN_RST;
      press_addr_q <= PRESSURE_ADDR_RST;
      soil_addr_q  <= SOIL_ADDR_RST;
      read_func_q  <= READ_FUNC_RST;
      press_cnt_q  <= PRESSURE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_FRAME_LEN:  max_len_q    <= cfg_wdata_i[4:0];
        REG_PRESSURE_ADDR:  press_addr_q <= cfg_wdata_i;
        REG_SOIL_ADDR:      soil_addr_q  <= cfg_wdata_i;
        REG_READ_FUNC:      read_func_q  <= cfg_wdata_i;
        REG_PRESSURE_COUNT: press_cnt_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage valids and handshake chain
  logic in_vld_q, raw_vld_q, out_vld_q;
  in_t  in_q;
  logic out_adv, raw_ready, in_drain, fire1;

  assign out_adv    = !out_vld_q || out_ready_i;
  assign raw_ready  = !raw_vld_q || out_adv;
  assign in_drain   = !in_q.last_byte || raw_ready;
  assign in_ready_o = !in_vld_q || in_drain;
  assign fire1      = in_vld_q && in_drain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  // frame state
  logic [15:0]       crc_q, crc_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              over_q, over_d;
  logic [7:0]        head_q [HEAD_KEEP];
  logic [7:0]        head_n [HEAD_KEEP];

  always_comb begin
    crc_d  = crc_byte(crc_q, in_q.rx_byte);
    cnt_d  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 5'd1;
    over_d = over_q || (cnt_q == COUNT_MAX);
    // bytes beyond this frame's length read as zero
    for (int i = 0; i < HEAD_KEEP; i++) begin
      if (cnt_q == CountW'(i)) begin
        head_n[i] = in_q.rx_byte;
      end else if (cnt_q > CountW'(i)) begin
        head_n[i] = head_q[i];
      end else begin
        head_n[i] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      cnt_q  <= '0;
      over_q <= 1'b0;
    end else if (fire1) begin
      if (in_q.last_byte) begin
        crc_q  <= CRC_INIT;
        cnt_q  <= '0;
        over_q <= 1'b0;
      end else begin
        crc_q  <= crc_d;
        cnt_q  <= cnt_d;
        over_q <= over_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1) begin
      for (int i = 0; i < HEAD_KEEP; i++) begin
        if (cnt_q == CountW'(i)) begin
          head_q[i] <= in_q.rx_byte;
        end
      end
    end
  end

  // frame decision
  logic       frame_ok;
  logic [1:0] kind_d;

  always_comb begin
    frame_ok = !over_d && (cnt_d >= MIN_FRAME_LEN) && (cnt_d <= max_len_q)
               && (crc_d == 16'h0000);
    if (frame_ok && head_n[0] == press_addr_q && head_n[1] == read_func_q
        && head_n[2] == press_cnt_q) begin
      kind_d = KIND_PRESSURE;
    end else if (frame_ok && head_n[0] == soil_addr_q) begin
      kind_d = KIND_SOIL;
    end else begin
      kind_d = KIND_FAIL;
    end
  end

  logic [1:0]  kind_q;
  logic [15:0] word34_q, word56_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_vld_q <= 1'b0;
    end else if (raw_ready) begin
      raw_vld_q <= fire1 && in_q.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_ready && fire1 && in_q.last_byte) begin
      kind_q   <= kind_d;
      word34_q <= {head_n[3], head_n[4]};
      word56_q <= {head_n[5], head_n[6]};
    end
  end

  // divide stage into output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= raw_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && raw_vld_q) begin
      out_o.result_kind <= kind_q;
      out_o.pressure    <= (kind_q == KIND_PRESSURE) ? word34_q : 16'h0000;
      out_o.humidity    <= (kind_q == KIND_SOIL) ? div10(word34_q) : 13'h0000;
      out_o.temperature <= (kind_q == KIND_SOIL) ? div10(word56_q) : 13'h0000;
    end
  end

  assign out_valid_o = out_vld_q;

  // checks
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire1 && in_q.last_byte |=> cnt_q == '0 && crc_q == CRC_INIT && !over_q)
    else $error("frame state not cleared after last byte");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire1 && !in_q.last_byte && cnt_q == COUNT_MAX |=> cnt_q == COUNT_MAX && over_q)
    else $error("byte count did not saturate");

  a_raw_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(raw_vld_q) |-> $past(fire1 && in_q.last_byte))
    else $error("result raised without a last byte");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_o.result_kind == KIND_FAIL || out_o.result_kind == KIND_PRESSURE
                  || out_o.result_kind == KIND_SOIL)
    else $error("illegal result kind");

  a_fields_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_o.result_kind != KIND_SOIL |-> out_o.humidity == '0
                                                  && out_o.temperature == '0)
    else $error("soil fields set on non-soil result");

endmodule
